// ===== rtl/core/hfv_pkg.sv =====
`default_nettype none
package hfv_pkg;
  localparam int MaxFrameBytes = 128;
  localparam int NumSlots = 4;
  localparam int PosW = 7;
  localparam int SlotW = 2;
  localparam int StoreAw = SlotW + PosW;
  localparam logic [7:0] Hdr0 = 8'h54;
  localparam logic [7:0] Hdr1 = 8'h47;

  typedef enum logic [2:0] {
    StOk = 3'd0,
    StParse = 3'd1,
    StHeader = 3'd2,
    StLength = 3'd3,
    StChecksum = 3'd4,
    StId = 3'd5,
    StRead = 3'd6
  } status_e;

  typedef struct packed {
    logic [2:0] status;
    logic [1:0] slot_index;
    logic [6:0] payload_length;
    logic [7:0] read_byte;
  } result_t;

  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/hex_frame_validator_with_id_table_top.sv =====
`default_nettype none
// ascii hex deframer: a hex character request is taken every cycle while the
// input is ready and gives no result. a rejected frame end posts its result in
// the cycle after acceptance. an accepted frame end copies the payload (bytes
// 3..n-2) from the staging ram to the slot store one byte per cycle over the
// staging read port and the store write port, behind the staging ram's
// registered read, then posts its result through the Emit state. a read
// request posts its result through the payload store's registered read port
// and the ReadWait and Emit states. the input is held off while a request is
// in progress or a result waits in the output register.
module hex_frame_validator_with_id_table_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        operation_i,
  input  wire logic [7:0]  hex_char_i,
  input  wire logic        frame_end_i,
  input  wire logic [1:0]  read_slot_i,
  input  wire logic [6:0]  read_offset_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [1:0]       slot_index_o,
  output logic [6:0]       payload_length_o,
  output logic [7:0]       read_byte_o,
  output logic [3:0]       collected_mask_o,
  output logic             all_collected_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  typedef enum logic [1:0] {Idle, Copy, ReadWait, Emit} state_e;
  state_e state_q;
  logic [15:0] id_q [hfv_pkg::NumSlots];
  logic [3:0] hi_q;
  logic pend_q, hdr_ok_q, pfail_q;
  logic [7:0] cnt_q, sum_q, prev_q, decl_q;
  logic [15:0] rid_q;
  logic [6:0] len_q [hfv_pkg::NumSlots];
  logic [3:0] coll_q;
  hfv_pkg::result_t res_q;
  logic [6:0] cp_q, cp_n_q;
  logic [1:0] slot_q;
  logic rd_zero_q;

  logic in_fire;
  logic [4:0] hv;
  logic [7:0] byte_v;
  logic take_byte;
  logic st_we;
  logic [6:0] st_ra;
  logic [7:0] st_rd;
  logic ps_we;
  logic [8:0] ps_wa, ps_ra;
  logic [7:0] ps_rd;

  assign in_ready_o = (state_q == Idle) && !out_valid_o;
  assign cfg_ready_o = 1'b1;
  assign in_fire = in_valid_i && in_ready_o;
  assign hv = hfv_pkg::hex_decode(hex_char_i);
  assign byte_v = {hi_q, hv[3:0]};
  assign take_byte = in_fire && !operation_i && !hv[4] && pend_q && !pfail_q;
  assign st_we = take_byte;
  assign st_ra = cp_q;
  // staging byte cp_q-1 lands this cycle and goes to payload offset cp_q-4
  assign ps_we = (state_q == Copy) && (cp_q != 7'd3);
  assign ps_wa = {slot_q, cp_q - 7'd4};
  assign ps_ra = (state_q == Idle) ? {read_slot_i, read_offset_i} : ps_wa;

  hfv_ram #(.Depth(hfv_pkg::MaxFrameBytes), .Aw(hfv_pkg::PosW)) u_stage (
    .clk_i, .we_i(st_we), .waddr_i(cnt_q[6:0]), .wdata_i(byte_v),
    .raddr_i(st_ra), .rdata_o(st_rd));
  hfv_ram #(.Depth(hfv_pkg::MaxFrameBytes * hfv_pkg::NumSlots), .Aw(hfv_pkg::StoreAw))
  u_store (
    .clk_i, .we_i(ps_we), .waddr_i(ps_wa), .wdata_i(st_rd),
    .raddr_i(ps_ra), .rdata_o(ps_rd));

  // frame checks on the final state, including the byte of this request
  logic [7:0] f_cnt, f_sum, f_prev, f_decl;
  logic [15:0] f_rid;
  logic f_hdr, f_pfail;
  logic [2:0] f_st;
  logic [1:0] f_slot;
  logic f_hit;
  always_comb begin
    f_cnt = cnt_q; f_sum = sum_q; f_prev = prev_q; f_decl = decl_q;
    f_rid = rid_q; f_hdr = hdr_ok_q; f_pfail = pfail_q;
    if (!operation_i && hv[4]) f_pfail = 1'b1;
    if (pend_q && !hv[4]) begin
      if (pfail_q) f_pfail = 1'b1;
      else begin
        f_sum = sum_q + byte_v;
        f_prev = byte_v;
        if (cnt_q == 8'd0 && byte_v != hfv_pkg::Hdr0) f_hdr = 1'b0;
        if (cnt_q == 8'd1 && byte_v != hfv_pkg::Hdr1) f_hdr = 1'b0;
        if (cnt_q == 8'd2) f_decl = byte_v;
        if (cnt_q == 8'd3) f_rid[7:0] = byte_v;
        if (cnt_q == 8'd4) f_rid[15:8] = byte_v;
        f_cnt = cnt_q + 8'd1;
        if (f_cnt >= 8'(hfv_pkg::MaxFrameBytes)) f_pfail = 1'b1;
      end
    end
    f_hit = 1'b0; f_slot = '0;
    for (int k = hfv_pkg::NumSlots - 1; k >= 0; k--) begin
      if (id_q[k] == f_rid) begin f_hit = 1'b1; f_slot = 2'(k); end
    end
    if (f_pfail) f_st = hfv_pkg::StParse;
    else if (f_cnt < 8'd5) f_st = hfv_pkg::StLength;
    else if (!f_hdr) f_st = hfv_pkg::StHeader;
    else if (f_decl != f_cnt - 8'd3) f_st = hfv_pkg::StLength;
    else if (8'(f_sum - f_prev) != f_prev) f_st = hfv_pkg::StChecksum;
    else if (!f_hit) f_st = hfv_pkg::StId;
    else f_st = hfv_pkg::StOk;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
      for (int k = 0; k < hfv_pkg::NumSlots; k++) begin
        id_q[k] <= 16'(k + 1);
        len_q[k] <= '0;
      end
      hi_q <= '0; pend_q <= 1'b0; hdr_ok_q <= 1'b1; pfail_q <= 1'b0;
      cnt_q <= '0; sum_q <= '0; prev_q <= '0; decl_q <= '0; rid_q <= '0;
      coll_q <= '0; out_valid_o <= 1'b0;
      cp_q <= '0; cp_n_q <= '0; slot_q <= '0; rd_zero_q <= 1'b0;
      res_q <= '0;
    end else begin
      if (cfg_valid_i) id_q[cfg_index_i] <= cfg_data_i;
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      case (state_q)
        Idle: begin
          if (in_fire && operation_i) begin
            res_q <= '{hfv_pkg::StRead, read_slot_i, len_q[read_slot_i], 8'd0};
            rd_zero_q <= read_offset_i >= len_q[read_slot_i];
            state_q <= ReadWait;
          end else if (in_fire && frame_end_i) begin
            hi_q <= '0; pend_q <= 1'b0; hdr_ok_q <= 1'b1; pfail_q <= 1'b0;
            cnt_q <= '0; sum_q <= '0; prev_q <= '0; decl_q <= '0; rid_q <= '0;
            if (f_st == hfv_pkg::StOk) begin
              res_q <= '{hfv_pkg::StOk, f_slot, 7'(f_cnt - 8'd4), 8'd0};
              slot_q <= f_slot;
              cp_q <= 7'd3;
              cp_n_q <= 7'(f_cnt - 8'd4);
              state_q <= Copy;
            end else begin
              res_q <= '{f_st, 2'd0, 7'd0, 8'd0};
              out_valid_o <= 1'b1;
            end
          end else if (in_fire) begin
            if (hv[4]) pfail_q <= 1'b1;
            else if (pend_q) begin
              pend_q <= 1'b0; hi_q <= '0;
              if (!pfail_q) begin
                sum_q <= f_sum; prev_q <= f_prev; hdr_ok_q <= f_hdr;
                decl_q <= f_decl; rid_q <= f_rid; cnt_q <= f_cnt;
              end
              pfail_q <= f_pfail;
            end else begin
              hi_q <= hv[3:0]; pend_q <= 1'b1;
            end
          end
        end
        Copy: begin
          if (cp_q == cp_n_q + 7'd3) begin
            len_q[slot_q] <= cp_n_q;
            coll_q[slot_q] <= 1'b1;
            state_q <= Emit;
          end else cp_q <= cp_q + 7'd1;
        end
        ReadWait: begin
          if (!rd_zero_q) res_q.read_byte <= ps_rd;
          state_q <= Emit;
        end
        Emit: begin
          out_valid_o <= 1'b1;
          state_q <= Idle;
        end
        default: state_q <= Idle;
      endcase
    end
  end

  assign status_o = res_q.status;
  assign slot_index_o = res_q.slot_index;
  assign payload_length_o = res_q.payload_length;
  assign read_byte_o = res_q.read_byte;
  assign collected_mask_o = coll_q;
  assign all_collected_o = &coll_q;
endmodule
`default_nettype wire

// ===== rtl/core/hfv_ram.sv =====
`default_nettype none
module hfv_ram #(
  parameter int Depth = 128,
  parameter int Aw = 7
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [Aw-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic [Aw-1:0] raddr_i,
  output logic [7:0]         rdata_o
);
  logic [7:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/core/hfv_checker.sv =====
`default_nettype none
module hfv_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [2:0] status_o,
  input wire logic [3:0] collected_mask_o,
  input wire logic       all_collected_o
);
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 3'd7) else $error("bad status");
  a_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    all_collected_o == (collected_mask_o == 4'hF)) else $error("all mismatch");
  a_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (($past(collected_mask_o) & ~collected_mask_o) == 4'h0)) else $error("mask cleared");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("out dropped");
  a_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("accept while full");
endmodule
bind hex_frame_validator_with_id_table_top hfv_checker u_chk (.*);
`default_nettype wire
